/* rtl/core/lfd_pkg.sv */
// Shared types and constants for the LIN frame deframer.
// No dependencies; imported by every module in rtl/core except lfd_checker.
package lfd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenW      = 4;
  localparam int unsigned NumSlots  = 8;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned FrameW    = 2 * ByteW + LenW + NumSlots * ByteW;  // 84
  localparam int unsigned TdataOutW = ((FrameW + 7) / 8) * 8;               // 88

  localparam logic [ByteW-1:0] SyncReset = 8'h55;
  localparam logic [LenW-1:0]  LenLong   = 4'd8;
  localparam logic [LenW-1:0]  LenMid    = 4'd4;
  localparam logic [LenW-1:0]  LenShort  = 4'd2;

  typedef enum logic [2:0] {
    ModeHunt    = 3'd0,
    ModeDiscard = 3'd1,
    ModeHeader  = 3'd2,
    ModeData    = 3'd3,
    ModeCheck   = 3'd4
  } lfd_mode_e;

  typedef struct packed {
    logic [ByteW-1:0]                checksum;
    logic [NumSlots-1:0][ByteW-1:0]  data;
    logic [LenW-1:0]                 length;
    logic [ByteW-1:0]                header;
  } lfd_frame_t;

  // Identifier bits 5:4 select the data length.
  function automatic logic [LenW-1:0] length_of_header(input logic [ByteW-1:0] hdr);
    logic [1:0] sel;
    sel = hdr[5:4];
    case (sel)
      2'd3:    length_of_header = LenLong;
      2'd2:    length_of_header = LenMid;
      default: length_of_header = LenShort;
    endcase
  endfunction

endpackage

/* rtl/core/lfd_parser.sv */
// Byte parser: frame state machine, held header, data slots.
// Depends on lfd_pkg.
module lfd_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      byte_valid_i,
  input  logic [lfd_pkg::ByteW-1:0] byte_i,
  input  logic [lfd_pkg::ByteW-1:0] sync_value_i,
  output logic                      frame_valid_o,
  output lfd_pkg::lfd_frame_t       frame_o
);
  import lfd_pkg::*;

  lfd_mode_e                       mode_q, mode_d;
  logic [ByteW-1:0]                header_q;
  logic [LenW-1:0]                 len_q;
  logic [IdxW-1:0]                 idx_q;
  logic [IdxW-1:0]                 idx_inc;
  logic [NumSlots-1:0][ByteW-1:0]  store_q;

  assign idx_inc = idx_q + IdxW'(1);

  // Next state
  always_comb begin
    mode_d = mode_q;
    if (byte_valid_i) begin
      case (mode_q)
        ModeHunt: begin
          if (byte_i != '0) begin
            mode_d = (byte_i == sync_value_i) ? ModeHeader : ModeDiscard;
          end
        end
        ModeDiscard: begin
          if (byte_i == '0) begin
            mode_d = ModeHunt;
          end
        end
        ModeHeader: mode_d = ModeData;
        ModeData: begin
          if (idx_inc >= len_q) begin
            mode_d = ModeCheck;
          end
        end
        ModeCheck: mode_d = ModeHunt;
        default:   mode_d = ModeHunt;
      endcase
    end
  end

  // Outputs: a frame leaves with its checksum byte.
  always_comb begin
    frame_valid_o     = byte_valid_i && (mode_q == ModeCheck);
    frame_o.header    = header_q;
    frame_o.length    = len_q;
    frame_o.data      = store_q;
    frame_o.checksum  = byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeHunt;
      header_q <= '0;
      len_q    <= '0;
      idx_q    <= '0;
      store_q  <= '0;
    end else begin
      mode_q <= mode_d;
      if (byte_valid_i) begin
        case (mode_q)
          ModeHeader: begin
            header_q <= byte_i;
            len_q    <= length_of_header(byte_i);
            idx_q    <= '0;
            store_q  <= '0;
          end
          ModeData: begin
            store_q[idx_q[2:0]] <= byte_i;
            idx_q               <= idx_inc;
          end
          ModeCheck: idx_q <= '0;
          default: ;
        endcase
      end
    end
  end

endmodule

/* rtl/core/lfd_out_reg.sv */
// Result register between the parser and the master stream side.
// Depends on lfd_pkg.
module lfd_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  lfd_pkg::lfd_frame_t in_frame_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output lfd_pkg::lfd_frame_t out_frame_o,
  input  logic                out_ready_i
);
  import lfd_pkg::*;

  logic       valid_q;
  lfd_frame_t frame_q;

  // Free slot, or the held frame leaves this cycle.
  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_frame_o = frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      frame_q <= in_frame_i;
    end
  end

endmodule

/* rtl/core/lin_frame_deframer_unit.sv */
// LIN frame deframer, top level.
// Depends on lfd_pkg, lfd_parser and lfd_out_reg.
//
// Slave stream (s_axis_*): one received bus byte per request in tdata.
// Master stream (m_axis_*): one complete frame per request, emitted when
// the checksum byte of a frame is taken in.
// Config channel (cfg_*): writes the sync byte value; always ready, and
// the new value applies from the next accepted byte on.
//
// Throughput: one byte per cycle while s_axis_tready is high. The frame
// shows on the master side in the cycle after its checksum byte is
// accepted; the single result register sets that delay.
// Stall: s_axis_tready is low exactly while a frame is held and
// m_axis_tready is low, so the slave side waits for the receiver; the held
// frame stays unchanged until taken, and no frame is lost or doubled.
// s_axis_tready follows m_axis_tready combinationally.
// Reset: the parser hunts for sync, all data slots clear, the sync value
// returns to 0x55 and the result register empties.
module lin_frame_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // master stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] frame_header, [11:8] data_length, [19:12] data_0 ... [75:68] data_7,
  // [83:76] frame_checksum, [87:84] zero
  output logic [87:0] m_axis_tdata_o,
  // config write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i        // sync_value
);
  import lfd_pkg::*;

  logic [ByteW-1:0] sync_q;
  logic             byte_acc;
  logic             frame_valid;
  lfd_frame_t       frame;
  lfd_frame_t       out_frame;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SyncReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sync_q <= cfg_data_i;
    end
  end

  assign byte_acc = s_axis_tvalid_i && s_axis_tready_o;

  lfd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_acc),
    .byte_i       (s_axis_tdata_i),
    .sync_value_i (sync_q),
    .frame_valid_o(frame_valid),
    .frame_o      (frame)
  );

  lfd_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (frame_valid),
    .in_frame_i (frame),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_frame_o(out_frame),
    .out_ready_i(m_axis_tready_i)
  );

  assign m_axis_tdata_o = {{(TdataOutW - FrameW){1'b0}}, out_frame};

endmodule

/* rtl/core/lfd_checker.sv */
// Port-level checks on the LIN frame deframer.
// Depends on lin_frame_deframer_unit; bound to it below.
module lfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tready_i,
  input logic        m_tvalid_i,
  input logic        m_tready_i,
  input logic [87:0] m_tdata_i
);

  // A held frame stays until taken.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i)
    else $error("frame dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> $stable(m_tdata_i))
    else $error("frame changed while stalled");

  // Input backpressure only when the result register is full and stalled.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_i == (!m_tvalid_i || m_tready_i))
    else $error("slave ready mismatch");

  // Length is always 2, 4 or 8.
  a_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> (m_tdata_i[11:8] == 4'd2 ||
                    m_tdata_i[11:8] == 4'd4 ||
                    m_tdata_i[11:8] == 4'd8))
    else $error("bad data length");

  // Unused slots read zero (checked for a two-byte length).
  a_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tdata_i[11:8] == 4'd2 |-> m_tdata_i[75:28] == '0)
    else $error("unused data slots not zero");

endmodule

bind lin_frame_deframer_unit lfd_checker u_lfd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .s_tready_i(s_axis_tready_o),
  .m_tvalid_i(m_axis_tvalid_o),
  .m_tready_i(m_axis_tready_i),
  .m_tdata_i (m_axis_tdata_o)
);

/* bench/lfd_frame_check.sv */
// Frame checker for lin_frame_deframer_unit: watches the byte, frame and sync-write
// channels, predicts each frame and compares it field by field.
// Depends on lfd_pkg for the frame layout and parser mode names.
module lfd_frame_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  // [7:0] header, [11:8] length, [75:12] data_0..data_7, [83:76] checksum
  input  logic [87:0] m_axis_tdata_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_data_i,       // sync_value
  output int          fault_count_o,
  output int          frames_owed_o,
  output int          frames_checked_o
);
  import lfd_pkg::*;

  // parser copy
  lfd_mode_e                      rx_mode;
  logic [ByteW-1:0]               sync_now;
  logic [ByteW-1:0]               hdr_held;
  logic [LenW-1:0]                len_due;
  logic [IdxW-1:0]                slot_idx;
  logic [NumSlots-1:0][ByteW-1:0] slot_bytes;

  lfd_frame_t frames_due[$];
  int         reported;

  task automatic note_field(input string field, input logic [7:0] want,
                            input logic [7:0] got);
    if (want !== got) begin
      fault_count_o++;
      reported++;
      if (reported <= 10)
        $display("  frame %0d: %s expected %02h, got %02h",
                 frames_checked_o, field, want, got);
    end
  endtask

  task automatic take_bus_byte(input logic [7:0] b);
    lfd_frame_t f;
    case (rx_mode)
      ModeHunt: begin
        if (b != '0) rx_mode = (b == sync_now) ? ModeHeader : ModeDiscard;
      end
      ModeDiscard: begin
        if (b == '0) rx_mode = ModeHunt;
      end
      ModeHeader: begin
        hdr_held = b;
        case (b[5:4])
          2'd3:    len_due = 4'd8;
          2'd2:    len_due = 4'd4;
          default: len_due = 4'd2;
        endcase
        slot_idx   = '0;
        slot_bytes = '0;
        rx_mode    = ModeData;
      end
      ModeData: begin
        slot_bytes[slot_idx[2:0]] = b;
        slot_idx = slot_idx + 1'b1;
        if (slot_idx >= len_due) rx_mode = ModeCheck;
      end
      ModeCheck: begin
        f.header = hdr_held;
        f.length = len_due;
        for (int k = 0; k < NumSlots; k++)
          f.data[k] = (k < len_due) ? slot_bytes[k] : '0;
        f.checksum = b;
        frames_due.insert(frames_due.size(), f);
        rx_mode  = ModeHunt;
        slot_idx = '0;
      end
      default: rx_mode = ModeHunt;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lfd_frame_t want, got;
    if (!rst_ni) begin
      rx_mode          = ModeHunt;
      sync_now         = 8'h55;
      hdr_held         = '0;
      len_due          = '0;
      slot_idx         = '0;
      slot_bytes       = '0;
      frames_due.delete();
      fault_count_o    = 0;
      frames_owed_o    = 0;
      frames_checked_o = 0;
      reported         = 0;
    end else begin
      // a frame leaving now belongs to a checksum taken at an earlier edge
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[FrameW-1:0];
        if (frames_due.size() == 0) begin
          fault_count_o++;
          reported++;
          if (reported <= 10)
            $display("  unexpected frame: hdr %02h len %0d cks %02h",
                     got.header, got.length, got.checksum);
        end else begin
          want = frames_due.pop_front();
          note_field("header", want.header, got.header);
          note_field("length", 8'(want.length), 8'(got.length));
          for (int k = 0; k < NumSlots; k++)
            note_field($sformatf("data_%0d", k), want.data[k], got.data[k]);
          note_field("checksum", want.checksum, got.checksum);
          note_field("pad", 8'h00, 8'(m_axis_tdata_i[TdataOutW-1:FrameW]));
          frames_checked_o++;
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) take_bus_byte(s_axis_tdata_i);
      // new sync applies from the next byte on
      if (cfg_valid_i && cfg_ready_i) sync_now = cfg_data_i;
      frames_owed_o = frames_due.size();
    end
  end

endmodule

/* bench/testbench.sv */
// Stimulus and verdict for lin_frame_deframer_unit: directed bytes, then
// random framed traffic under several sync values; lfd_frame_check does the checking.
// Depends on lfd_pkg, lin_frame_deframer_unit and lfd_frame_check.
module testbench;
  import lfd_pkg::*;

  localparam int StallLimit  = 500;  // cycles with no request accepted on any channel
  localparam int QuietCycles = 8;    // well past a frame's passage through the result register

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [87:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  int faults, owed, checked;
  int bytes_sent, syncs_used;
  int idle_cycles = 0;
  bit no_gaps;  // shared by both sides: a stretch with no idling

  logic [7:0] opening_seq [22];
  logic [7:0] sync_plan [6];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  lin_frame_deframer_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  lfd_frame_check u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid_i  (s_tvalid),
    .s_axis_tready_i  (s_tready),
    .s_axis_tdata_i   (s_tdata),
    .m_axis_tvalid_i  (m_tvalid),
    .m_axis_tready_i  (m_tready),
    .m_axis_tdata_i   (m_tdata),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .fault_count_o    (faults),
    .frames_owed_o    (owed),
    .frames_checked_o (checked)
  );

  // Byte value biased toward zero and all-ones.
  function automatic logic [7:0] bus_byte();
    case ($urandom_range(0, 7))
      0, 1:    return 8'h00;
      2:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One byte request. Called and returns at a falling edge; valid stays high
  // across back-to-back requests so it is never dropped and raised in one step.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (bytes_sent % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk_i); while (!s_tready);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Sync, header, data, checksum; now and then leading zeros, and now and
  // then cut short so the next bytes land inside the open frame.
  task automatic send_frame(input logic [7:0] sync);
    int pad, len, cut;
    logic [7:0] hdr;
    pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (pad) send_byte(8'h00);
    hdr = 8'($urandom_range(0, 255));
    len = (hdr[5:4] == 2'd3) ? 8 : (hdr[5:4] == 2'd2) ? 4 : 2;
    cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, len) : len + 1;
    send_byte(sync);
    send_byte(hdr);
    for (int k = 0; k < cut; k++) send_byte(bus_byte());
  endtask

  // Wrong lead byte, some junk, then the zero that ends the discard.
  task automatic send_garble(input logic [7:0] sync);
    int n;
    logic [7:0] lead;
    do lead = 8'($urandom_range(1, 255)); while (lead == sync);
    send_byte(lead);
    n = $urandom_range(0, 3);
    repeat (n) send_byte(8'($urandom_range(1, 255)));
    send_byte(8'h00);
  endtask

  // Let every owed frame drain, then a few more cycles for any late one.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (owed != 0) @(negedge clk_i);
    repeat (QuietCycles) @(negedge clk_i);
  endtask

  task automatic write_sync(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    syncs_used++;
  endtask

  // Receiver back-pressure: a fresh random stall, at times none, before each frame request.
  initial begin
    int hold;
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      @(negedge clk_i);
    end
  end

  // Watchdog: a stretch with no request accepted on any channel ends the run.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= StallLimit) begin
      $display("watchdog: nothing accepted for %0d cycles, %0d frames owed",
               StallLimit, owed);
      $display("RESULT: ERROR");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int target;
    rst_ni      = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    bytes_sent  = 0;
    syncs_used  = 0;
    no_gaps     = 1'b0;

    // Directed, under the reset sync value 0x55:
    //   zeros skipped while hunting; zero header and zero data/checksum kept;
    //   discard mode ignores a sync byte until a zero; parity bits in the
    //   header with a four-byte body; length select 1 falls back to two bytes.
    opening_seq = '{8'h00, 8'h00,
                    8'h55, 8'h00, 8'h00, 8'hFF, 8'h00,
                    8'hA3, 8'h55, 8'h00,
                    8'h55, 8'hE0, 8'hFF, 8'h00, 8'h80, 8'h01, 8'hFF,
                    8'h55, 8'h10, 8'h12, 8'h34, 8'hAB};
    // Extremes first: all-ones, then zero (no frame can start), then the
    // usual value, then others.
    sync_plan = '{8'hFF, 8'h00, 8'h55, 8'($urandom_range(2, 254)), 8'h01,
                  8'($urandom_range(1, 255))};

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (opening_seq[i]) send_byte(opening_seq[i]);

    foreach (sync_plan[p]) begin
      settle();
      write_sync(sync_plan[p]);
      if (sync_plan[p] == 8'h00) begin
        // every nonzero byte only discards here
        target = bytes_sent + 90;
        while (bytes_sent < target) begin
          if ($urandom_range(0, 2) == 0) send_garble(sync_plan[p]);
          else send_byte(bus_byte());
        end
      end else begin
        target = bytes_sent + 365;
        while (bytes_sent < target) begin
          case ($urandom_range(0, 9))
            7:       send_garble(sync_plan[p]);
            8, 9:    send_byte(bus_byte());
            default: send_frame(sync_plan[p]);
          endcase
        end
      end
    end

    settle();
    $display("Covered %0d bus bytes over %0d sync settings (0x00, 0xFF among them);",
             bytes_sent, syncs_used + 1);
    $display("%0d frames compared field by field, %0d field faults.", checked, faults);
    if (faults == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
